>>> rtl/bbl_pkg.sv
// Shared types and constants for the byte-budget LRU entry table.
`timescale 1ns / 1ps
`default_nettype none
package bbl_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int SLOT_W      = 6;   // slot number width, covers up to 64 entries
  localparam int CNT_W       = 6;
  localparam int TOT_W       = 40;
  localparam int WORD_W      = 32;
  localparam int IN_DATA_W   = 168;
  localparam int OUT_DATA_W  = 120;

  typedef enum logic [2:0] {
    OP_PUT, OP_GET, OP_CONTAINS, OP_REMOVE, OP_MOVE, OP_MARK, OP_CLEAR, OP_TRIM
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_EVICT, ST_STATUS
  } state_t;

  // Write and clear command broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic              key_en;
    logic [WORD_W-1:0] key;
    logic              fid_en;
    logic [WORD_W-1:0] fid;
    logic              vs_en;
    logic [WORD_W-1:0] ver;
    logic [WORD_W-1:0] size;
    logic              time_en;
    logic [WORD_W-1:0] last_use;
    logic              live_en;
    logic              live;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_idx;
  } cell_wr_t;

  // Search parameters broadcast to every cell.
  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] dst;
    logic              keep_en;
    logic [SLOT_W-1:0] keep_idx;
    logic              prio;
  } scan_cmd_t;

  // Running search result handed from cell to cell.
  typedef struct packed {
    logic              m_found;
    logic [SLOT_W-1:0] m_idx;
    logic [WORD_W-1:0] m_ver;
    logic [WORD_W-1:0] m_size;
    logic [WORD_W-1:0] m_fid;
    logic              m_live;
    logic              d_found;
    logic [SLOT_W-1:0] d_idx;
    logic [WORD_W-1:0] d_size;
    logic [WORD_W-1:0] d_fid;
    logic              f_found;
    logic [SLOT_W-1:0] f_idx;
    logic              v_found;
    logic [SLOT_W-1:0] v_idx;
    logic              v_live;
    logic [WORD_W-1:0] v_time;
    logic [WORD_W-1:0] v_size;
    logic [WORD_W-1:0] v_fid;
    logic [WORD_W-1:0] v_key;
  } cand_t;

endpackage
`default_nettype wire

>>> rtl/byte_budget_lru_entry_table_top.sv
// Top level of the byte-budget LRU entry table: controller and chain of entry cells.
// A search runs through the cell chain, then the result is decided in ST_DECIDE. A refused
// put or a move onto its own key skips the search. put and trim evict until the total fits
// the budget, clear removes one entry per search; result stalls can hold the controller and
// one item is worked on at a time.
// Reset (synchronous, active low) clears all valid bits, totals and the cap, sets next id to 1.
`timescale 1ns / 1ps
`default_nettype none
module byte_budget_lru_entry_table_top import bbl_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream. tdata from bit 0 up: opcode(3), key(32), dst_key(32), version_tag(32),
  // size_bytes(32), now_time(32), source_exists(1), volume_mounted(1), zero fill.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. tdata from bit 0 up: file_id(32), file_key(32), hit, demoted, refused,
  // total_bytes(40), entry_count(6), zero fill. tuser: result_kind. tlast: last.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast,
  // Byte budget register.
  input  wire logic                  cfg_wr_en,
  input  wire logic [TOT_W-1:0]      cfg_wr_data
);

  localparam int SCW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [SCW-1:0] SCAN_LAST = SCW'(ENTRIES - 1);

  // Fields of the incoming transfer.
  op_t               in_op;
  logic [WORD_W-1:0] in_key, in_dst, in_ver, in_size, in_now;
  logic              in_exists, in_mounted, in_fire, in_refused;

  assign in_op      = op_t'(in_tdata[2:0]);
  assign in_key     = in_tdata[34:3];
  assign in_dst     = in_tdata[66:35];
  assign in_ver     = in_tdata[98:67];
  assign in_size    = in_tdata[130:99];
  assign in_now     = in_tdata[162:131];
  assign in_exists  = in_tdata[163];
  assign in_mounted = in_tdata[164];

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [WORD_W-1:0] key_r, key_nxt, dst_r, dst_nxt, ver_r, ver_nxt;
  logic [WORD_W-1:0] size_r, size_nxt, now_r, now_nxt;
  logic              exists_r, exists_nxt, mounted_r, mounted_nxt;
  logic [TOT_W-1:0]  cap_r, cap_nxt, total_r, total_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] next_id_r, next_id_nxt, id_r, id_nxt, nid_inc;
  logic              hit_r, hit_nxt, dem_r, dem_nxt, ref_r, ref_nxt;
  logic              keep_en_r, keep_en_nxt, prio_r, prio_nxt, evict_r, evict_nxt;
  logic [SLOT_W-1:0] keep_idx_r, keep_idx_nxt;
  logic [SCW-1:0]    cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_free;

  cell_wr_t  wr;
  scan_cmd_t sc;
  cand_t     chain [ENTRIES+1];
  cand_t     res;

  // Drop selection for the decision cycle.
  logic              dec_drop, stall;
  logic [SLOT_W-1:0] d_idx;
  logic [WORD_W-1:0] d_size, d_fid, d_key;
  logic [TOT_W-1:0]  tot_after_drop;
  logic [CNT_W-1:0]  cnt_after_drop;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_refused = (in_size == '0) || (cap_r == '0) || (TOT_W'(in_size) > cap_r);
  assign out_free   = !out_valid_r || out_tready;
  assign res        = chain[ENTRIES];

  assign sc.key      = key_r;
  assign sc.dst      = dst_r;
  assign sc.keep_en  = keep_en_r;
  assign sc.keep_idx = keep_idx_r;
  assign sc.prio     = prio_r;

  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bbl_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (wr),
      .sc     (sc),
      .cand_i (chain[g]),
      .cand_o (chain[g+1])
    );
  end

  always_comb begin
    dec_drop = 1'b0;
    if (evict_r) begin
      dec_drop = res.v_found;
    end else begin
      case (op_r)
        OP_PUT:    dec_drop = !res.m_found && !res.f_found;
        OP_REMOVE: dec_drop = res.m_found;
        OP_MOVE:   dec_drop = res.m_found && res.d_found;
        OP_CLEAR:  dec_drop = res.v_found;
        default:   dec_drop = 1'b0;
      endcase
    end
  end

  assign stall = (state_r == ST_DECIDE) && dec_drop && !out_free;

  // Remove drops the matched entry, move the one at the destination key, all else the victim.
  always_comb begin
    d_idx  = res.v_idx;
    d_size = res.v_size;
    d_fid  = res.v_fid;
    d_key  = res.v_key;
    if (!evict_r && (op_r == OP_REMOVE)) begin
      d_idx  = res.m_idx;
      d_size = res.m_size;
      d_fid  = res.m_fid;
      d_key  = key_r;
    end else if (!evict_r && (op_r == OP_MOVE)) begin
      d_idx  = res.d_idx;
      d_size = res.d_size;
      d_fid  = res.d_fid;
      d_key  = dst_r;
    end
  end

  assign tot_after_drop = total_r - TOT_W'(d_size);
  assign cnt_after_drop = count_r - CNT_W'(1);
  assign nid_inc        = next_id_r + WORD_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_PUT:  state_nxt = in_refused ? ST_STATUS : ST_SCAN;
            OP_MOVE: state_nxt = (in_key == in_dst) ? ST_STATUS : ST_SCAN;
            OP_TRIM: state_nxt = ST_EVICT;
            default: state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_LAST) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stall) begin
          if (evict_r) begin
            state_nxt = res.v_found ? ST_EVICT : ST_STATUS;
          end else begin
            case (op_r)
              OP_PUT:   state_nxt = ST_EVICT;
              OP_CLEAR: state_nxt = res.v_found ? ST_SCAN : ST_STATUS;
              default:  state_nxt = ST_STATUS;
            endcase
          end
        end
      end
      ST_EVICT: begin
        state_nxt = (total_r > cap_r) ? ST_SCAN : ST_STATUS;
      end
      ST_STATUS: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_nxt       = op_r;
    key_nxt      = key_r;
    dst_nxt      = dst_r;
    ver_nxt      = ver_r;
    size_nxt     = size_r;
    now_nxt      = now_r;
    exists_nxt   = exists_r;
    mounted_nxt  = mounted_r;
    cap_nxt      = cfg_wr_en ? cfg_wr_data : cap_r;
    total_nxt    = total_r;
    count_nxt    = count_r;
    next_id_nxt  = next_id_r;
    id_nxt       = id_r;
    hit_nxt      = hit_r;
    dem_nxt      = dem_r;
    ref_nxt      = ref_r;
    keep_en_nxt  = keep_en_r;
    keep_idx_nxt = keep_idx_r;
    prio_nxt     = prio_r;
    evict_nxt    = evict_r;
    cnt_nxt      = '0;
    wr           = '0;
    out_kind_nxt = out_kind_r;
    out_last_nxt = out_last_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          key_nxt     = in_key;
          dst_nxt     = in_dst;
          ver_nxt     = in_ver;
          size_nxt    = in_size;
          now_nxt     = in_now;
          exists_nxt  = in_exists;
          mounted_nxt = in_mounted;
          ref_nxt     = (in_op == OP_PUT) && in_refused;
          hit_nxt     = 1'b0;
          dem_nxt     = 1'b0;
          id_nxt      = '0;
          keep_en_nxt = 1'b0;
          prio_nxt    = (in_op != OP_CLEAR);
          evict_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + SCW'(1);
      end
      ST_EVICT: begin
        if (total_r > cap_r) evict_nxt = 1'b1;
      end
      ST_DECIDE: begin
        if (!stall) begin
          if (dec_drop) begin
            wr.clr_en     = 1'b1;
            wr.clr_idx    = d_idx;
            total_nxt     = tot_after_drop;
            count_nxt     = cnt_after_drop;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = 1'b1;
            out_last_nxt  = 1'b0;
            out_data_nxt  = {7'b0, cnt_after_drop, tot_after_drop, 3'b000, d_key, d_fid};
          end
          if (!evict_r) begin
            case (op_r)
              OP_PUT: begin
                wr.en       = 1'b1;
                wr.vs_en    = 1'b1;
                wr.ver      = ver_r;
                wr.size     = size_r;
                wr.time_en  = 1'b1;
                wr.last_use = now_r;
                wr.live_en  = 1'b1;
                wr.live     = 1'b1;
                keep_en_nxt = 1'b1;
                if (res.m_found) begin
                  wr.idx       = res.m_idx;
                  keep_idx_nxt = res.m_idx;
                  id_nxt       = res.m_fid;
                  total_nxt    = total_r - TOT_W'(res.m_size) + TOT_W'(size_r);
                end else begin
                  // New entry in a free slot, or in the slot of the victim just dropped.
                  wr.idx       = res.f_found ? res.f_idx : res.v_idx;
                  keep_idx_nxt = wr.idx;
                  wr.key_en    = 1'b1;
                  wr.key       = key_r;
                  wr.fid_en    = 1'b1;
                  wr.fid       = next_id_r;
                  id_nxt       = next_id_r;
                  next_id_nxt  = (nid_inc == '0) ? WORD_W'(1) : nid_inc;
                  if (res.f_found) begin
                    total_nxt = total_r + TOT_W'(size_r);
                    count_nxt = count_r + CNT_W'(1);
                  end else begin
                    total_nxt = tot_after_drop + TOT_W'(size_r);
                    count_nxt = count_r;
                  end
                end
              end
              OP_GET, OP_CONTAINS: begin
                if (res.m_found && (res.m_ver == ver_r)) begin
                  hit_nxt = 1'b1;
                  id_nxt  = res.m_fid;
                  if (op_r == OP_GET) begin
                    wr.en       = 1'b1;
                    wr.idx      = res.m_idx;
                    wr.time_en  = 1'b1;
                    wr.last_use = now_r;
                    wr.live_en  = 1'b1;
                    wr.live     = 1'b1;
                  end
                end
              end
              OP_MOVE: begin
                if (res.m_found) begin
                  wr.en      = 1'b1;
                  wr.idx     = res.m_idx;
                  wr.key_en  = 1'b1;
                  wr.key     = dst_r;
                  wr.live_en = 1'b1;
                  wr.live    = 1'b1;
                end
              end
              OP_MARK: begin
                if (res.m_found && mounted_r) begin
                  wr.idx = res.m_idx;
                  if (!exists_r && res.m_live) begin
                    wr.en      = 1'b1;
                    wr.live_en = 1'b1;
                    wr.live    = 1'b0;
                    dem_nxt    = 1'b1;
                  end else if (exists_r && !res.m_live) begin
                    wr.en      = 1'b1;
                    wr.live_en = 1'b1;
                    wr.live    = 1'b1;
                  end
                end
              end
              OP_CLEAR: begin
                if (!res.v_found) total_nxt = '0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {7'b0, count_r, total_r, ref_r, dem_r, hit_r, {WORD_W{1'b0}}, id_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= '0;
      total_r     <= '0;
      count_r     <= '0;
      next_id_r   <= WORD_W'(1);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      evict_r     <= 1'b0;
      keep_en_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      evict_r     <= evict_nxt;
      keep_en_r   <= keep_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    dst_r      <= dst_nxt;
    ver_r      <= ver_nxt;
    size_r     <= size_nxt;
    now_r      <= now_nxt;
    exists_r   <= exists_nxt;
    mounted_r  <= mounted_nxt;
    id_r       <= id_nxt;
    hit_r      <= hit_nxt;
    dem_r      <= dem_nxt;
    ref_r      <= ref_nxt;
    keep_idx_r <= keep_idx_nxt;
    prio_r     <= prio_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= SCAN_LAST))
    else $error("search counter overran the chain");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DECIDE) && !evict_r && (op_r == OP_CLEAR) && !res.v_found)
      |=> ((total_r == '0) && (count_r == '0)))
    else $error("clear left entries or bytes behind");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DECIDE) && dec_drop) |-> (count_r != '0))
    else $error("entry dropped from an empty table");

endmodule
`default_nettype wire

>>> rtl/bbl_cell.sv
// One table entry with its stage of the registered search chain.
`timescale 1ns / 1ps
`default_nettype none
module bbl_cell import bbl_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_wr_t  wr,
  input  wire scan_cmd_t sc,
  input  wire cand_t     cand_i,
  output cand_t          cand_o
);

  localparam logic [SLOT_W-1:0] MY = SLOT_W'(IDX);

  logic              valid_r;
  logic [WORD_W-1:0] key_r, ver_r, size_r, time_r, fid_r;
  logic              live_r;
  cand_t             cand_r, cand_nxt;
  logic              wr_hit, clr_hit, elig;

  assign wr_hit  = wr.en && (wr.idx == MY);
  assign clr_hit = wr.clr_en && (wr.clr_idx == MY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit && wr.key_en) begin
      valid_r <= 1'b1;
    end else if (clr_hit) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      if (wr.key_en) key_r <= wr.key;
      if (wr.fid_en) fid_r <= wr.fid;
      if (wr.vs_en) begin
        ver_r  <= wr.ver;
        size_r <= wr.size;
      end
      if (wr.time_en) time_r <= wr.last_use;
      if (wr.live_en) live_r <= wr.live;
    end
  end

  assign elig = valid_r && !(sc.keep_en && (sc.keep_idx == MY));

  always_comb begin
    cand_nxt = cand_i;
    if (!cand_i.m_found && valid_r && (key_r == sc.key)) begin
      cand_nxt.m_found = 1'b1;
      cand_nxt.m_idx   = MY;
      cand_nxt.m_ver   = ver_r;
      cand_nxt.m_size  = size_r;
      cand_nxt.m_fid   = fid_r;
      cand_nxt.m_live  = live_r;
    end
    if (!cand_i.d_found && valid_r && (key_r == sc.dst)) begin
      cand_nxt.d_found = 1'b1;
      cand_nxt.d_idx   = MY;
      cand_nxt.d_size  = size_r;
      cand_nxt.d_fid   = fid_r;
    end
    if (!cand_i.f_found && !valid_r) begin
      cand_nxt.f_found = 1'b1;
      cand_nxt.f_idx   = MY;
    end
    // With prio, demoted beats live, then the older time (ties keep the lower slot); else lowest slot wins.
    if (elig && (!cand_i.v_found ||
                 (sc.prio && ((live_r != cand_i.v_live) ? !live_r
                                                         : (time_r < cand_i.v_time))))) begin
      cand_nxt.v_found = 1'b1;
      cand_nxt.v_idx   = MY;
      cand_nxt.v_live  = live_r;
      cand_nxt.v_time  = time_r;
      cand_nxt.v_size  = size_r;
      cand_nxt.v_fid   = fid_r;
      cand_nxt.v_key   = key_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_o = cand_r;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the byte-budget LRU entry table top level.
`timescale 1ns / 1ps
module tb_top;
  import bbl_pkg::*;

  localparam int NSLOT = ENTRIES_DEF;
  localparam logic [39:0] CAP_MAX = 40'hFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 4000000;

  // One result as the block reports it.
  typedef struct {
    bit        kind;
    bit [31:0] fid;
    bit [31:0] fkey;
    bit        hit;
    bit        dem;
    bit        refd;
    bit [39:0] total;
    bit [5:0]  count;
    bit        lst;
  } table_result_t;

  // One operation sent to the block.
  typedef struct {
    op_t       op;
    bit [31:0] key;
    bit [31:0] dst;
    bit [31:0] ver;
    bit [31:0] size;
    bit [31:0] now;
    bit        exists;
    bit        mounted;
  } table_op_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [TOT_W-1:0]      cfg_wr_data = '0;

  byte_budget_lru_entry_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table, kept in step with every accepted transfer.
  bit        tbl_valid[NSLOT];
  bit [31:0] tbl_key[NSLOT];
  bit [31:0] tbl_ver[NSLOT];
  bit [31:0] tbl_size[NSLOT];
  bit [31:0] tbl_time[NSLOT];
  bit        tbl_live[NSLOT];
  bit [31:0] tbl_fid[NSLOT];
  bit [39:0] tbl_total = '0;
  bit [31:0] tbl_next_fid = 32'd1;
  bit [39:0] budget = '0;

  table_result_t pending_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  idle_free = 1'b0;     // when set, neither side inserts gaps
  int  key_pool = 8;         // random keys mostly come from a small pool
  int  size_ceiling = 100;

  function automatic bit [5:0] live_entries();
    bit [5:0] n = 0;
    for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  function automatic void push_result(bit kind, bit [31:0] fid, bit [31:0] fkey,
                                      bit hit, bit dem, bit refd, bit lst);
    table_result_t r;
    r.kind = kind; r.fid = fid; r.fkey = fkey; r.hit = hit; r.dem = dem; r.refd = refd;
    r.total = tbl_total; r.count = live_entries(); r.lst = lst;
    pending_results.push_back(r);
  endfunction

  function automatic int slot_of(bit [31:0] k);
    for (int i = 0; i < NSLOT; i++) if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void evict_slot(int i);
    tbl_total = tbl_total - tbl_size[i];
    tbl_valid[i] = 1'b0;
    push_result(1'b1, tbl_fid[i], tbl_key[i], 1'b0, 1'b0, 1'b0, 1'b0);
  endfunction

  // Demoted entries go first, then the oldest, then the lowest slot.
  function automatic int choose_victim(int keep);
    int best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_valid[i] || i == keep) continue;
      if (best < 0) best = i;
      else if (tbl_live[i] != tbl_live[best]) begin
        if (!tbl_live[i]) best = i;
      end else if (tbl_time[i] < tbl_time[best]) best = i;
    end
    return best;
  endfunction

  function automatic void shrink_to_budget(int keep);
    int v;
    while (tbl_total > budget) begin
      v = choose_victim(keep);
      if (v < 0) break;
      evict_slot(v);
    end
  endfunction

  // Works out every result that one operation causes.
  function automatic void predict_table_op(table_op_t t);
    bit [31:0] id = 0;
    bit hit = 0, dem = 0, refd = 0;
    int s, d;
    case (t.op)
      OP_PUT: begin
        if (t.size == 0 || budget == 0 || {8'd0, t.size} > budget) refd = 1;
        else begin
          s = slot_of(t.key);
          if (s >= 0) tbl_total = tbl_total - tbl_size[s];
          else begin
            s = -1;
            for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
            if (s < 0) begin
              s = choose_victim(-1);
              evict_slot(s);
            end
            tbl_fid[s] = tbl_next_fid;
            tbl_next_fid++;
            if (tbl_next_fid == 0) tbl_next_fid = 1;
            tbl_key[s] = t.key;
            tbl_valid[s] = 1'b1;
          end
          tbl_ver[s] = t.ver; tbl_size[s] = t.size; tbl_time[s] = t.now;
          tbl_live[s] = 1'b1;
          tbl_total = tbl_total + t.size;
          id = tbl_fid[s];
          shrink_to_budget(s);
        end
      end
      OP_GET, OP_CONTAINS: begin
        s = slot_of(t.key);
        if (s >= 0 && tbl_ver[s] == t.ver) begin
          hit = 1; id = tbl_fid[s];
          if (t.op == OP_GET) begin
            tbl_time[s] = t.now; tbl_live[s] = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        s = slot_of(t.key);
        if (s >= 0) evict_slot(s);
      end
      OP_MOVE: begin
        s = slot_of(t.key);
        if (t.key != t.dst && s >= 0) begin
          d = slot_of(t.dst);
          if (d >= 0) evict_slot(d);
          tbl_key[s] = t.dst; tbl_live[s] = 1'b1;
        end
      end
      OP_MARK: begin
        s = slot_of(t.key);
        if (s >= 0 && t.mounted) begin
          if (!t.exists && tbl_live[s]) begin
            tbl_live[s] = 1'b0; dem = 1;
          end else if (t.exists) tbl_live[s] = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) evict_slot(i);
        tbl_total = 0;
      end
      default: shrink_to_budget(-1);
    endcase
    push_result(1'b0, id, 32'd0, hit, dem, refd, 1'b1);
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_length();
    int r = $urandom_range(0, 99);
    if (idle_free) return 0;
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side stall pattern, redrawn whenever the last stall has run out.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!idle_free && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_length();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compares each accepted result transfer with the oldest expectation.
  always @(posedge clk) begin
    table_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation waiting: tdata %h", out_tdata);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.kind) begin
          $error("result_kind: expected %0d, got %0d", e.kind, out_tuser); error_count++;
        end
        if (out_tdata[31:0] !== e.fid) begin
          $error("file_id: expected %0h, got %0h", e.fid, out_tdata[31:0]); error_count++;
        end
        if (out_tdata[63:32] !== e.fkey) begin
          $error("file_key: expected %0h, got %0h", e.fkey, out_tdata[63:32]); error_count++;
        end
        if (out_tdata[64] !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_tdata[64]); error_count++;
        end
        if (out_tdata[65] !== e.dem) begin
          $error("demoted: expected %0d, got %0d", e.dem, out_tdata[65]); error_count++;
        end
        if (out_tdata[66] !== e.refd) begin
          $error("refused: expected %0d, got %0d", e.refd, out_tdata[66]); error_count++;
        end
        if (out_tdata[106:67] !== e.total) begin
          $error("total_bytes: expected %0d, got %0d", e.total, out_tdata[106:67]);
          error_count++;
        end
        if (out_tdata[112:107] !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, out_tdata[112:107]);
          error_count++;
        end
        if (out_tlast !== e.lst) begin
          $error("last: expected %0d, got %0d", e.lst, out_tlast); error_count++;
        end
      end
    end
  end

  // A generous watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Sends one operation; the prediction is made at the accepting edge. The valid stays
  // high afterwards so that a following transfer can go back to back.
  task automatic send_op(table_op_t t);
    int g = gap_length();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'd0, t.mounted, t.exists, t.now, t.size, t.ver, t.dst, t.key, t.op};
    do @(posedge clk); while (!in_tready);
    predict_table_op(t);
  endtask

  task automatic issue(op_t op, bit [31:0] key, bit [31:0] ver = 0, bit [31:0] size = 0,
                       bit [31:0] now = 0, bit [31:0] dst = 0, bit ex = 0, bit mt = 0);
    table_op_t t;
    t.op = op; t.key = key; t.dst = dst; t.ver = ver; t.size = size; t.now = now;
    t.exists = ex; t.mounted = mt;
    send_op(t);
  endtask

  // Lowers the input valid and waits until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // The budget is written only while the block is idle.
  task automatic set_budget(bit [39:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    budget = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Puts are refused with a zero budget, a zero size or a size over the budget; one that fills it is taken.
  task automatic test_refused_puts();
    issue(OP_PUT, 32'd1, 32'd1, 32'd5, 32'd10);
    set_budget(40'd100);
    issue(OP_PUT, 32'd1, 32'd1, 32'd0, 32'd10);
    issue(OP_PUT, 32'd1, 32'd1, 32'd101, 32'd10);
    issue(OP_PUT, 32'd1, 32'd7, 32'd100, 32'd10);
  endtask

  // Every operation and its corner cases on a small budget.
  task automatic test_each_operation();
    issue(OP_GET, 32'd1, 32'd7, 0, 32'd20);               // hit, refreshes time
    issue(OP_GET, 32'd1, 32'd8, 0, 32'd21);               // version mismatch
    issue(OP_CONTAINS, 32'd1, 32'd7);
    issue(OP_CONTAINS, 32'd2, 32'd7);                     // miss
    issue(OP_PUT, 32'd2, 32'd3, 32'd40, 32'd30);          // evicts the full first entry
    issue(OP_PUT, 32'd3, 32'd3, 32'd40, 32'd31);
    issue(OP_PUT, 32'd2, 32'd4, 32'd20, 32'd32);          // known key keeps its file id
    issue(OP_MOVE, 32'd2, 0, 0, 0, 32'd2);                // same key
    issue(OP_MOVE, 32'd9, 0, 0, 0, 32'd5);                // missing source
    issue(OP_MOVE, 32'd2, 0, 0, 0, 32'd3);                // destination taken
    issue(OP_MARK, 32'd3, 0, 0, 0, 0, 1'b0, 1'b0);        // volume not mounted
    issue(OP_PUT, 32'd4, 32'd0, 32'd30, 32'd40);
    issue(OP_MARK, 32'd4, 0, 0, 0, 0, 1'b0, 1'b1);        // demote
    issue(OP_MARK, 32'd3, 0, 0, 0, 0, 1'b0, 1'b1);        // demote
    issue(OP_MARK, 32'd3, 0, 0, 0, 0, 1'b1, 1'b1);        // back to live
    issue(OP_REMOVE, 32'd77);                             // missing key
    set_budget(40'd25);
    issue(OP_TRIM, 32'd0);                                // demoted entry goes first
    issue(OP_REMOVE, 32'd3);
    issue(OP_PUT, 32'd6, 32'd1, 32'd25, 32'd50);
    issue(OP_CLEAR, 32'd0);
  endtask

  // Extreme keys, times and sizes under the largest budget.
  task automatic test_field_extremes();
    set_budget(CAP_MAX);
    issue(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_PUT, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    issue(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0000);
    issue(OP_MOVE, 32'd0, 0, 0, 0, 32'hFFFF_FFFF);
  endtask

  function automatic bit [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return 32'h5A00_0000 + $urandom_range(0, key_pool - 1);
    return $urandom;
  endfunction

  task automatic random_ops(int n);
    table_op_t t;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 38) t.op = OP_PUT;
      else if (r < 56) t.op = OP_GET;
      else if (r < 63) t.op = OP_CONTAINS;
      else if (r < 71) t.op = OP_REMOVE;
      else if (r < 79) t.op = OP_MOVE;
      else if (r < 92) t.op = OP_MARK;
      else if (r < 93) t.op = OP_CLEAR;
      else t.op = OP_TRIM;
      t.key = pick_key();
      t.dst = ($urandom_range(0, 9) == 0) ? t.key : pick_key();
      t.ver = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 3) t.size = 0;
      else if (r < 7) t.size = $urandom;
      else t.size = $urandom_range(1, size_ceiling);
      t.now = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
      t.exists = $urandom_range(0, 1);
      t.mounted = ($urandom_range(0, 4) != 0);
      send_op(t);
    end
  endtask

  // Random phases over several budgets; the second one is large enough to fill the table.
  task automatic test_random_traffic();
    set_budget(40'd5000);
    key_pool = 12; size_ceiling = 1500;
    random_ops(110);
    set_budget(CAP_MAX);
    key_pool = 48; size_ceiling = 100000;
    random_ops(90);
    drain_results();                 // sender holds off until everything is back
    idle_free = 1'b1;
    random_ops(60);
    idle_free = 1'b0;
    set_budget(40'd3000);
    issue(OP_TRIM, 32'd0);
    key_pool = 10; size_ceiling = 800;
    random_ops(110);
    set_budget(40'd1);
    key_pool = 4; size_ceiling = 1;
    random_ops(40);
    set_budget(40'd0);
    random_ops(20);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_refused_puts();
    test_each_operation();
    test_field_extremes();
    test_random_traffic();
    drain_results();
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
